@@ sv/pvtkwi_pkg.sv @@
package pvtkwi_pkg;

  localparam int VERTEX_W = 12;
  localparam int BONE_W   = 8;
  localparam int WEIGHT_W = 16;
  localparam int POS_W    = 3;
  localparam int MARK_W   = 3;
  localparam int CFG_W    = 4;
  localparam int SLOT_W   = BONE_W + WEIGHT_W;
  localparam int ROW_CAP  = 8;
  localparam int VEXT_W   = 17;

  localparam logic [CFG_W-1:0] ACTIVE_SLOTS_RESET = 4'd8;

  // command handed from the front end to the back end
  typedef struct packed {
    logic                is_read;
    logic                out_of_range;
    logic [VERTEX_W-1:0] vertex;
    logic [BONE_W-1:0]   bone;
    logic [WEIGHT_W-1:0] weight;
  } cmd_t;

  typedef struct packed {
    logic                inserted;
    logic [POS_W-1:0]    pos;
    logic [BONE_W-1:0]   bone;
    logic [WEIGHT_W-1:0] weight;
    logic [MARK_W-1:0]   mark;
    logic                last;
  } res_t;

endpackage

@@ sv/pvtkwi_front.sv @@
module pvtkwi_front
  import pvtkwi_pkg::*;
#(
  parameter int VERTEX_COUNT = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  logic                s_action_i,
  input  logic [VERTEX_W-1:0] s_vertex_i,
  input  logic [BONE_W-1:0]   s_bone_i,
  input  logic [WEIGHT_W-1:0] s_weight_i,
  input  logic                clearing_i,
  output logic                push_o,
  output cmd_t                push_data_o,
  input  logic                full_i
);

  logic hold_v_q, hold_v_d;
  cmd_t hold_q;
  logic take;

  assign push_o      = hold_v_q && !full_i;
  assign push_data_o = hold_q;
  assign s_ready_o   = (!hold_v_q || push_o) && !clearing_i;
  assign take        = s_valid_i && s_ready_o;

  always_comb begin
    hold_v_d = hold_v_q;
    if (take) begin
      hold_v_d = 1'b1;
    end else if (push_o) begin
      hold_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
    end else begin
      hold_v_q <= hold_v_d;
    end
  end

  // classify on entry: action and vertex range
  always_ff @(posedge clk_i) begin
    if (take) begin
      hold_q.is_read      <= s_action_i;
      hold_q.out_of_range <= (VEXT_W'(s_vertex_i) >= VEXT_W'(VERTEX_COUNT));
      hold_q.vertex       <= s_vertex_i;
      hold_q.bone         <= s_bone_i;
      hold_q.weight       <= s_weight_i;
    end
  end

endmodule

@@ sv/pvtkwi_cmd_fifo.sv @@
module pvtkwi_cmd_fifo
  import pvtkwi_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t head_o,
  output logic empty_o
);

  cmd_t       entries_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ sv/pvtkwi_back.sv @@
module pvtkwi_back
  import pvtkwi_pkg::*;
#(
  parameter int VERTEX_COUNT = 4096,
  parameter int MAX_SLOTS    = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  cmd_t             head_i,
  input  logic             empty_i,
  output logic             pop_o,
  output logic             clearing_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output res_t             res_o
);

  localparam int ROW_LIMIT = (MAX_SLOTS < ROW_CAP) ? MAX_SLOTS : ROW_CAP;
  localparam int ROW_W     = ROW_LIMIT * SLOT_W;
  localparam int AW        = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
  localparam int CW        = (ROW_LIMIT > 1) ? $clog2(ROW_LIMIT) : 1;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_LOOK  = 4'b0100,
    ST_DUMP  = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [AW-1:0]    clr_cnt_q, clr_cnt_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [MARK_W-1:0] mark_q, mark_d;
  logic [CFG_W-1:0] cfg_q;
  logic             out_v_q;
  res_t             res_q, res_d;
  cmd_t             cur_q;

  logic [ROW_W-1:0] mem_q [VERTEX_COUNT];
  logic [ROW_W-1:0] rd_row_q;
  logic             rd_en, wr_en, load;
  logic [AW-1:0]    rd_addr, wr_addr, cur_addr;
  logic [ROW_W-1:0] wr_data;

  logic [CFG_W-1:0]  n_used;
  logic [VEXT_W-1:0] head_vext, cur_vext;
  logic              out_free;

  logic              found;
  logic [CW-1:0]     pos;
  logic [CFG_W-1:0]  stop_at;
  logic [MARK_W-1:0] passed, mark_new;
  logic [ROW_W-1:0]  row_shift, row_new;
  logic [CW-1:0]     sel_idx;
  logic [SLOT_W-1:0] sel_slot;

  // clamp the register to 1..ROW_LIMIT
  always_comb begin
    if (cfg_q == '0) begin
      n_used = CFG_W'(1);
    end else if (cfg_q > CFG_W'(ROW_LIMIT)) begin
      n_used = CFG_W'(ROW_LIMIT);
    end else begin
      n_used = cfg_q;
    end
  end

  assign head_vext = VEXT_W'(head_i.vertex);
  assign cur_vext  = VEXT_W'(cur_q.vertex);
  assign rd_addr   = head_vext[AW-1:0];
  assign cur_addr  = cur_vext[AW-1:0];
  assign out_free  = !out_v_q || res_ready_i;

  // find the first active slot whose weight lies below the new one
  always_comb begin
    logic [WEIGHT_W-1:0] w_k;
    found = 1'b0;
    pos   = '0;
    for (int k = 0; k < ROW_LIMIT; k++) begin
      w_k = rd_row_q[k*SLOT_W +: WEIGHT_W];
      if (!found && (CFG_W'(k) < n_used) && (cur_q.weight > w_k)) begin
        found = 1'b1;
        pos   = CW'(k);
      end
    end
  end

  assign stop_at  = found ? CFG_W'(pos) : n_used;
  assign passed   = MARK_W'(stop_at - CFG_W'(1));
  assign mark_new = ((stop_at != '0) && (passed > mark_q)) ? passed : mark_q;

  // slot k of row_shift holds old slot k-1
  assign row_shift = ROW_W'({rd_row_q, {SLOT_W{1'b0}}});

  always_comb begin
    row_new = rd_row_q;
    for (int k = 0; k < ROW_LIMIT; k++) begin
      if (CFG_W'(k) == stop_at) begin
        row_new[k*SLOT_W +: SLOT_W] = {cur_q.bone, cur_q.weight};
      end else if ((CFG_W'(k) > stop_at) && (CFG_W'(k) < n_used)) begin
        row_new[k*SLOT_W +: SLOT_W] = row_shift[k*SLOT_W +: SLOT_W];
      end
    end
  end

  assign sel_idx  = (state_q == ST_DUMP) ? cnt_q : '0;
  assign sel_slot = rd_row_q[sel_idx*SLOT_W +: SLOT_W];

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    cnt_d     = cnt_q;
    mark_d    = mark_q;
    pop_o     = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = clr_cnt_q;
    wr_data   = '0;
    load      = 1'b0;
    res_d     = '0;
    res_d.mark = mark_q;
    case (state_q)
      ST_CLEAR: begin
        wr_en = 1'b1;
        if (clr_cnt_q == AW'(VERTEX_COUNT - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (!empty_i) begin
          if (head_i.out_of_range) begin
            if (out_free) begin
              pop_o      = 1'b1;
              load       = 1'b1;
              res_d.last = 1'b1;
            end
          end else begin
            pop_o   = 1'b1;
            rd_en   = 1'b1;
            state_d = ST_LOOK;
          end
        end
      end
      ST_LOOK: begin
        if (out_free) begin
          load = 1'b1;
          if (cur_q.is_read) begin
            res_d.pos    = '0;
            res_d.bone   = sel_slot[SLOT_W-1 -: BONE_W];
            res_d.weight = sel_slot[WEIGHT_W-1:0];
            res_d.last   = (n_used == CFG_W'(1));
            cnt_d        = CW'(1);
            state_d      = (n_used == CFG_W'(1)) ? ST_IDLE : ST_DUMP;
          end else begin
            wr_en          = found;
            wr_addr        = cur_addr;
            wr_data        = row_new;
            mark_d         = mark_new;
            res_d.inserted = found;
            res_d.pos      = found ? POS_W'(pos) : '0;
            res_d.bone     = found ? cur_q.bone : '0;
            res_d.weight   = found ? cur_q.weight : '0;
            res_d.mark     = mark_new;
            res_d.last     = 1'b1;
            state_d        = ST_IDLE;
          end
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          load         = 1'b1;
          res_d.pos    = POS_W'(cnt_q);
          res_d.bone   = sel_slot[SLOT_W-1 -: BONE_W];
          res_d.weight = sel_slot[WEIGHT_W-1:0];
          res_d.last   = (CFG_W'(cnt_q) == (n_used - CFG_W'(1)));
          cnt_d        = cnt_q + 1'b1;
          if (res_d.last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d   = ST_CLEAR;
        clr_cnt_d = '0;
      end
    endcase
    // a register write restarts the clearing sweep
    if (cfg_we_i) begin
      state_d   = ST_CLEAR;
      clr_cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      cnt_q     <= '0;
      mark_q    <= '0;
      cfg_q     <= ACTIVE_SLOTS_RESET;
      out_v_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      cnt_q     <= cnt_d;
      mark_q    <= mark_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (load) begin
        out_v_q <= 1'b1;
      end else if (res_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
    if (pop_o) begin
      cur_q <= head_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_row_q <= mem_q[rd_addr];
    end
  end

  assign clearing_o  = (state_q == ST_CLEAR);
  assign res_valid_o = out_v_q;
  assign res_o       = res_q;

endmodule

@@ sv/per_vertex_top_k_weight_insert.sv @@
// Per-vertex top-k bone weight list.
// Input stream (s_axis_*): one transaction is an insert (tuser = 0) or a
// read (tuser = 1) of one vertex row. Output stream (m_axis_*): an insert
// or an out-of-range vertex gives one result; a read gives one result per
// active slot, in slot order, with tlast on the final one.
// cfg_we_i/cfg_wdata_i set the active slot count; write only when idle.
// An input passes the front-end holding register, the command queue, the
// row read and the output register; an out-of-range vertex skips the row
// read. An insert is a row read, then compare, shift and write back on the
// single-port row memory; a read is a row read, then one result per active
// slot. The back end takes a new command only once the last one is done.
// Reset and every register write start a clearing sweep of all VERTEX_COUNT
// rows, one row a cycle; s_axis_tready stays low until it ends.
// A two-entry command queue sits between front and back, and the output
// register holds a result while m_axis_tready is low; the back end then
// stalls, the queue fills, and s_axis_tready drops.
module per_vertex_top_k_weight_insert
  import pvtkwi_pkg::*;
#(
  parameter int VERTEX_COUNT = 4096,
  parameter int MAX_SLOTS    = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // vertex_index[11:0], bone_index[19:12], weight[35:20], zero[39:36]
  input  logic [39:0]      s_axis_tdata,
  // action[0]
  input  logic             s_axis_tuser,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // slot_position[2:0], slot_bone[10:3], slot_weight[26:11],
  // high_slot_mark[29:27], zero[31:30]
  output logic [31:0]      m_axis_tdata,
  // inserted[0]
  output logic             m_axis_tuser,
  output logic             m_axis_tlast
);

  logic push, full, pop, empty, clearing;
  cmd_t push_data, head;
  res_t res;

  pvtkwi_front #(
    .VERTEX_COUNT(VERTEX_COUNT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .s_action_i (s_axis_tuser),
    .s_vertex_i (s_axis_tdata[11:0]),
    .s_bone_i   (s_axis_tdata[19:12]),
    .s_weight_i (s_axis_tdata[35:20]),
    .clearing_i (clearing),
    .push_o     (push),
    .push_data_o(push_data),
    .full_i     (full)
  );

  pvtkwi_cmd_fifo u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (full),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (empty)
  );

  pvtkwi_back #(
    .VERTEX_COUNT(VERTEX_COUNT),
    .MAX_SLOTS   (MAX_SLOTS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .head_i     (head),
    .empty_i    (empty),
    .pop_o      (pop),
    .clearing_o (clearing),
    .res_valid_o(m_axis_tvalid),
    .res_ready_i(m_axis_tready),
    .res_o      (res)
  );

  assign m_axis_tdata = {2'b00, res.mark, res.weight, res.bone, res.pos};
  assign m_axis_tuser = res.inserted;
  assign m_axis_tlast = res.last;

endmodule

@@ test/weight_slot_check.sv @@
`timescale 1ns / 100ps

// Watches both streams and the register port, keeps a copy of every vertex row
// and of the passed-slot mark, and compares each slot report with the oldest
// expectation.
module weight_slot_check
  import pvtkwi_pkg::*;
#(
  parameter int VERTEX_COUNT = 4096,
  parameter int MAX_SLOTS    = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             s_axis_tvalid,
  input  logic             s_axis_tready,
  input  logic [39:0]      s_axis_tdata,
  input  logic             s_axis_tuser,
  input  logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  logic [31:0]      m_axis_tdata,
  input  logic             m_axis_tuser,
  input  logic             m_axis_tlast,
  output int               fail_count_o,
  output int               outstanding_o
);

  localparam int ROW_SLOTS = (MAX_SLOTS < ROW_CAP) ? MAX_SLOTS : ROW_CAP;

  logic [BONE_W-1:0]   bone_rows   [VERTEX_COUNT][MAX_SLOTS];
  logic [WEIGHT_W-1:0] weight_rows [VERTEX_COUNT][MAX_SLOTS];
  logic [MARK_W-1:0]   passed_mark;
  logic [CFG_W-1:0]    slot_setting;
  res_t                slot_reports [$];
  int                  mismatches;

  function automatic int slots_in_use();
    int n;
    n = slot_setting;
    if (n < 1) n = 1;
    if (n > ROW_SLOTS) n = ROW_SLOTS;
    return n;
  endfunction

  task automatic clear_rows();
    for (int v = 0; v < VERTEX_COUNT; v++) begin
      for (int s = 0; s < MAX_SLOTS; s++) begin
        bone_rows[v][s]   = '0;
        weight_rows[v][s] = '0;
      end
    end
  endtask

  // Append one expected slot report at the tail.
  task automatic add_report(input res_t rep);
    slot_reports.insert(slot_reports.size(), rep);
  endtask

  // Work out the slot reports of one operation and update the rows and the mark.
  task automatic apply_operation(input logic rd, input logic [VERTEX_W-1:0] vtx,
                                 input logic [BONE_W-1:0] bone,
                                 input logic [WEIGHT_W-1:0] wt);
    int   n;
    int   i;
    int   j;
    res_t r;
    n = slots_in_use();
    r = '0;
    r.last = 1'b1;
    if (int'(vtx) >= VERTEX_COUNT) begin
      r.mark = passed_mark;
      add_report(r);
    end else if (rd) begin
      for (i = 0; i < n; i++) begin
        r.inserted = 1'b0;
        r.pos      = POS_W'(i);
        r.bone     = bone_rows[vtx][i];
        r.weight   = weight_rows[vtx][i];
        r.mark     = passed_mark;
        r.last     = (i == n - 1);
        add_report(r);
      end
    end else begin
      i = 0;
      while (i < n && !(wt > weight_rows[vtx][i])) i++;
      // slots 0..i-1 were passed over
      if (i > 0 && (i - 1) > int'(passed_mark)) passed_mark = MARK_W'(i - 1);
      if (i < n) begin
        for (j = n - 1; j > i; j--) begin
          bone_rows[vtx][j]   = bone_rows[vtx][j-1];
          weight_rows[vtx][j] = weight_rows[vtx][j-1];
        end
        bone_rows[vtx][i]   = bone;
        weight_rows[vtx][i] = wt;
        r.inserted = 1'b1;
        r.pos      = POS_W'(i);
        r.bone     = bone;
        r.weight   = wt;
      end
      r.mark = passed_mark;
      add_report(r);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      clear_rows();
      passed_mark  = '0;
      slot_setting = ACTIVE_SLOTS_RESET;
      slot_reports.delete();
      mismatches   = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (slot_reports.size() == 0) begin
          $error("slot report with no operation pending");
          mismatches++;
        end else begin
          want = slot_reports.pop_front();
          check_field("inserted", want.inserted, m_axis_tuser);
          check_field("slot_position", want.pos, m_axis_tdata[POS_W-1:0]);
          check_field("slot_bone", want.bone, m_axis_tdata[POS_W +: BONE_W]);
          check_field("slot_weight", want.weight,
                      m_axis_tdata[POS_W+BONE_W +: WEIGHT_W]);
          check_field("high_slot_mark", want.mark,
                      m_axis_tdata[POS_W+BONE_W+WEIGHT_W +: MARK_W]);
          check_field("last", want.last, m_axis_tlast);
        end
      end
      // a register write also wipes every row, but keeps the mark
      if (cfg_we_i) begin
        slot_setting = cfg_wdata_i;
        clear_rows();
      end
      if (s_axis_tvalid && s_axis_tready)
        apply_operation(s_axis_tuser, s_axis_tdata[VERTEX_W-1:0],
                        s_axis_tdata[VERTEX_W +: BONE_W],
                        s_axis_tdata[VERTEX_W+BONE_W +: WEIGHT_W]);
    end
    fail_count_o  <= mismatches;
    outstanding_o <= slot_reports.size();
  end

endmodule

@@ test/per_vertex_top_k_weight_insert_test.sv @@
`timescale 1ns / 100ps

module per_vertex_top_k_weight_insert_test;
  import pvtkwi_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 43;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             cfg_we_i      = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i   = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [39:0]      s_axis_tdata  = '0;
  logic             s_axis_tuser  = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [31:0]      m_axis_tdata;
  logic             m_axis_tuser;
  logic             m_axis_tlast;

  int fail_count;
  int outstanding;
  int idle_cycles    = 0;
  int items_sent     = 0;
  int results_seen   = 0;
  int settings_used  = 0;
  bit no_gaps        = 1'b0;
  bit hold_request   = 1'b0;
  bit hold_done      = 1'b0;

  per_vertex_top_k_weight_insert dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  weight_slot_check slot_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Offer one operation and hold it until the transaction completes.
  task automatic send_op(input logic rd, input logic [VERTEX_W-1:0] vtx,
                         input logic [BONE_W-1:0] bone,
                         input logic [WEIGHT_W-1:0] wt);
    int r;
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= rd;
    s_axis_tdata  <= {4'b0, wt, bone, vtx};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) gap = 0;
    else if (r < 94) gap = $urandom_range(1, 3);
    else gap = $urandom_range(12, 40);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic write_slot_count(input logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    settings_used++;
  endtask

  // stimulus
  initial begin
    logic [CFG_W-1:0]    settings [6];
    logic [VERTEX_W-1:0] pool [4];
    logic [VERTEX_W-1:0] vtx;
    logic [WEIGHT_W-1:0] wt;
    logic                rd;
    int                  p;
    int                  k;
    int                  r;
    settings = '{4'd0, 4'd15, 4'd3, 4'd1, 4'd8, 4'd6};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    settings_used = 1;

    // Directed part at the reset slot count of 8.
    send_op(1'b0, 12'd0, 8'h00, 16'h8000);
    send_op(1'b0, 12'd0, 8'h11, 16'h4000);
    send_op(1'b0, 12'd0, 8'h22, 16'h2000);
    send_op(1'b0, 12'd0, 8'h33, 16'h6000);
    // equal weight goes behind the existing one
    send_op(1'b0, 12'd0, 8'h44, 16'h4000);
    send_op(1'b1, 12'd0, 8'h00, 16'h0000);
    send_op(1'b0, 12'd4095, 8'hFF, 16'hFFFF);
    send_op(1'b0, 12'd4095, 8'h80, 16'h0001);
    for (k = 0; k < 8; k++)
      send_op(1'b0, 12'd1, 8'(k + 1), 16'h9000 - 16'(k) * 16'h1000);
    // full row: a small weight passes every slot and saturates the mark
    send_op(1'b0, 12'd1, 8'h5A, 16'h0001);
    // the last slot falls off
    send_op(1'b0, 12'd1, 8'hAA, 16'hFFFF);
    send_op(1'b1, 12'd1, 8'hFF, 16'hFFFF);
    send_op(1'b0, 12'd2, 8'h77, 16'h0000);
    send_op(1'b1, 12'd4095, 8'h00, 16'h0000);
    send_op(1'b1, 12'd2, 8'h00, 16'h0000);

    for (p = 0; p < 6; p++) begin
      drain_results();
      write_slot_count(settings[p]);
      no_gaps = (p == 1) || (p == 4);
      // let the output side stall long enough to back up the input
      if (p == 1) begin
        // wait out the clearing sweep so the stall meets live traffic
        do @(posedge clk_i); while (!s_axis_tready);
        hold_request = 1'b1;
      end
      for (k = 0; k < 4; k++) pool[k] = VERTEX_W'($urandom_range(0, 4095));
      for (k = 0; k < PHASE_ITEMS; k++) begin
        r   = $urandom_range(0, 99);
        vtx = (r < 10) ? VERTEX_W'($urandom) : pool[$urandom_range(0, 3)];
        rd  = ($urandom_range(0, 99) < 25);
        r   = $urandom_range(0, 99);
        if (r < 8) wt = '0;
        else if (r < 14) wt = '1;
        else if (r < 40) wt = WEIGHT_W'($urandom_range(1, 8)) << 12;
        else if (r < 45) wt = WEIGHT_W'(1);
        else wt = WEIGHT_W'($urandom);
        send_op(rd, vtx, BONE_W'($urandom), wt);
      end
    end
    drain_results();
    repeat (10) @(posedge clk_i);

    $display("Sent %0d operations over %0d slot-count settings, checked %0d slot reports",
             items_sent, settings_used, results_seen);
    $display("Covered ties, zero and full-scale weights, row overflow, long output stall");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // output side ready pattern
  initial begin
    int   r;
    int   len;
    logic lvl;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_request && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          lvl = 1'b1;
          len = $urandom_range(1, 6);
        end else if (r < 60) begin
          lvl = 1'b1;
          len = $urandom_range(15, 40);
        end else if (r < 95) begin
          lvl = 1'b0;
          len = $urandom_range(1, 3);
        end else begin
          lvl = 1'b0;
          len = $urandom_range(10, 40);
        end
        m_axis_tready <= lvl;
        repeat (len) @(posedge clk_i);
      end
    end
  end

  // Count cycles without any transaction; give up when the limit is hit.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (m_axis_tvalid && m_axis_tready) results_seen <= results_seen + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule
